@@ rtl/core/sks_pkg.sv @@
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types and constants of the sorted key store.
// ----------------------------------------------------------------------------
`default_nettype none

package sks_pkg;

  localparam int KeyW     = 32;
  localparam int PayloadW = 32;
  localparam int PosInW   = 4;
  localparam int PosOutW  = 5;
  localparam int CountW   = 5;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

endpackage

`default_nettype wire

@@ rtl/core/sks_ram.sv @@
// ----------------------------------------------------------------------------
// sks_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/sorted_key_store_search_insert.sv @@
// ----------------------------------------------------------------------------
// sorted_key_store_search_insert
// One sorted node of key/value entries with find, insert and read commands.
// ----------------------------------------------------------------------------
// Entries live in one RAM with a registered read port, and a single 32-bit
// key comparator does the binary search. Each search step is a RAM read,
// then a compare. Insert then moves up each entry at or above the position,
// drains the last copy and writes the new entry; with nothing to move only
// the write is done, and an insert into a full node skips both the move
// and the write. Read fetches the entry at the position from the RAM. The
// block takes one command at a time; the next command is accepted as soon as
// the previous one has left its result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_store_search_insert
  import sks_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          cmd_i,
  input  wire logic [KeyW-1:0]     key_i,
  input  wire logic [PayloadW-1:0] payload_i,
  input  wire logic [PosInW-1:0]   position_in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               status_o,
  output logic                     found_o,
  output logic [PosOutW-1:0]       position_out_o,
  output logic [KeyW-1:0]          key_out_o,
  output logic [PayloadW-1:0]      payload_out_o,
  output logic [CountW-1:0]        entry_count_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int VW = VALUE_WIDTH;
  localparam int EW = KeyW + VW;
  localparam int PW = IW + PosInW;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SRCH  = 6'b000010,
    S_CMP   = 6'b000100,
    S_SHIFT = 6'b001000,
    S_RDATA = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;

  cmd_e             cmd_q, cmd_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [VW-1:0]    val_q, val_d;
  logic [CW-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0]    j_q, j_d, pend_addr_q, pend_addr_d;
  status_e          res_status_q, res_status_d;
  logic             res_found_q, res_found_d;
  logic [CW-1:0]    res_pos_q, res_pos_d;
  logic [KeyW-1:0]  res_key_q, res_key_d;
  logic [VW-1:0]    res_val_q, res_val_d;

  logic [1:0]         o_status_q;
  logic               o_found_q;
  logic [PosOutW-1:0] o_pos_q;
  logic [KeyW-1:0]    o_key_q;
  logic [PayloadW-1:0] o_val_q;
  logic [CountW-1:0]  o_count_q;
  logic               load_out;

  logic           ram_we;
  logic [IW-1:0]  ram_waddr, ram_raddr;
  logic [EW-1:0]  ram_wdata, ram_rdata;

  logic [CW:0]           lohi_sum;
  logic [CW-1:0]         mid;
  logic [PW-1:0]         pin_ext, cnt_ext;
  logic [VW+PayloadW-1:0] val_in_ext;
  logic [KeyW-1:0]       rd_key;
  logic [VW-1:0]         rd_val;
  logic                  srch_done;
  logic                  srch_found;
  logic [CW-1:0]         srch_pos;
  logic                  do_rd;
  logic [CW-1:0]         j_minus;

  sks_ram #(
    .Width(EW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign lohi_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = lohi_sum[CW:1];
  assign pin_ext    = {{IW{1'b0}}, position_in_i};
  assign cnt_ext    = {{(PW - CW){1'b0}}, count_q};
  assign val_in_ext = {{VW{1'b0}}, payload_i};
  assign rd_key     = ram_rdata[KeyW-1:0];
  assign rd_val     = ram_rdata[EW-1:KeyW];
  assign do_rd      = (j_q != res_pos_q);
  assign j_minus    = j_q - 1'b1;

  assign in_ready_o = (state_q == S_IDLE);
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pend_d       = pend_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    val_d        = val_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    j_d          = j_q;
    pend_addr_d  = pend_addr_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_pos_d    = res_pos_q;
    res_key_d    = res_key_q;
    res_val_d    = res_val_q;
    ram_we       = 1'b0;
    ram_waddr    = res_pos_q[IW-1:0];
    ram_wdata    = {val_q, key_q};
    ram_raddr    = mid[IW-1:0];
    srch_done    = 1'b0;
    srch_found   = 1'b0;
    srch_pos     = lo_q;

    case (state_q)
      S_IDLE: begin
        ram_raddr = pin_ext[IW-1:0];
        if (in_valid_i) begin
          cmd_d        = cmd_e'(cmd_i);
          key_d        = key_i;
          val_d        = val_in_ext[VW-1:0];
          lo_d         = '0;
          hi_d         = count_q;
          res_status_d = ST_OK;
          res_found_d  = 1'b0;
          res_pos_d    = '0;
          res_key_d    = '0;
          res_val_d    = '0;
          case (cmd_e'(cmd_i))
            CMD_FIND, CMD_INSERT: state_d = S_SRCH;
            CMD_READ: begin
              if (pin_ext < cnt_ext) begin
                state_d = S_RDATA;
              end else begin
                res_status_d = ST_RANGE;
                state_d      = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SRCH: begin
        mid_d = mid;
        if (lo_q == hi_q) begin
          srch_done = 1'b1;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (key_q == rd_key) begin
          srch_done  = 1'b1;
          srch_found = 1'b1;
          srch_pos   = mid_q;
        end else begin
          if (key_q < rd_key) begin
            hi_d = mid_q;
          end else begin
            lo_d = mid_q + 1'b1;
          end
          state_d = S_SRCH;
        end
      end
      S_SHIFT: begin
        // reads walk down one entry ahead of the trailing writes
        ram_raddr = j_minus[IW-1:0];
        pend_d    = do_rd;
        if (do_rd) begin
          pend_addr_d = j_q;
          j_d         = j_minus;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q[IW-1:0];
          ram_wdata = ram_rdata;
        end else if (!do_rd) begin
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
          state_d = S_DONE;
        end
      end
      S_RDATA: begin
        res_key_d = rd_key;
        res_val_d = rd_val;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (srch_done) begin
      res_found_d = srch_found;
      res_pos_d   = srch_pos;
      state_d     = S_DONE;
      if (cmd_q == CMD_INSERT) begin
        if (count_q >= CapC) begin
          res_status_d = ST_FULL;
        end else begin
          j_d     = count_q;
          pend_d  = 1'b0;
          state_d = S_SHIFT;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    val_q        <= val_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    j_q          <= j_d;
    pend_addr_q  <= pend_addr_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_pos_q    <= res_pos_d;
    res_key_q    <= res_key_d;
    res_val_q    <= res_val_d;
  end

  logic [CW+PosOutW-1:0]   pos_ext;
  logic [CW+CountW-1:0]    cnt_out_ext;
  logic [VW+PayloadW-1:0]  val_out_ext;

  assign pos_ext     = {{PosOutW{1'b0}}, res_pos_q};
  assign cnt_out_ext = {{CountW{1'b0}}, count_q};
  assign val_out_ext = {{PayloadW{1'b0}}, res_val_q};

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_status_q <= res_status_q;
      o_found_q  <= res_found_q;
      o_pos_q    <= pos_ext[PosOutW-1:0];
      o_key_q    <= res_key_q;
      o_val_q    <= val_out_ext[PayloadW-1:0];
      o_count_q  <= cnt_out_ext[CountW-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = o_status_q;
  assign found_o        = o_found_q;
  assign position_out_o = o_pos_q;
  assign key_out_o      = o_key_q;
  assign payload_out_o  = o_val_q;
  assign entry_count_o  = o_count_q;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + 1'b1) && ($past(state_q) == S_SHIFT))
    else $error("entry count changed outside an insert");

  a_we_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SHIFT))
    else $error("store written outside the insert phase");

  a_srch_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH || state_q == S_CMP) |-> (lo_q <= hi_q) && (hi_q <= count_q))
    else $error("search window out of order");

  a_shift_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && pend_q) |-> (pend_addr_q > res_pos_q))
    else $error("move writes at or below the insertion point");
`endif

endmodule

`default_nettype wire
